// ===== hw/rtl/chcb_pkg.sv =====
// Package for the canonical Huffman code builder.
// Shared widths, defaults, operation codes, FSM states and ctrl/datapath structs.
// No dependencies.
package chcb_pkg;

	localparam int SYMBOLS_DEF = 288;
	localparam int MAX_LEN_DEF = 15;

	localparam int OP_W       = 2;
	localparam int SYM_W      = 9;
	localparam int LEN_W      = 4;
	localparam int CODE_OUT_W = 15;
	localparam int CNT_DEPTH  = 16;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;
	localparam int S_PAD_W   = S_TDATA_W - SYM_W - LEN_W;
	localparam int M_PAD_W   = M_TDATA_W - CODE_OUT_W - LEN_W;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_RD_LEN,
		ST_RANK,
		ST_FIRST,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_start;
		logic clr_step;
		logic ld_issue;
		logic ld_commit;
		logic rd_issue;
		logic rd_latch;
		logic rank_step;
		logic first_step;
		logic sum;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sym_ok;
		logic clr_done;
		logic rd_skip;
		logic scan_done;
		logic first_done;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/canonical_huffman_code_builder_top.sv =====
// Top level of the canonical Huffman code builder (DEFLATE code assignment).
// Instantiates chcb_ctrl and chcb_dp; depends on chcb_pkg.
//
// Channel   Dir  Signals                      Contents
// s_axis    in   tdata[15:0], tuser[1:0]      item: operation, symbol, code_length
// m_axis    out  tdata[23:0], tuser[0]        result of a read: code, length_out, over_full
//
// Load: the item is taken in ST_IDLE and written in ST_LOAD. Clear: a sweep writes
// zero to every entry of the length memory. Read: ST_RD_LEN, the rank scan (ST_RANK),
// the first-code steps (ST_FIRST) and ST_SUM, then ST_DONE; a zero length or an
// out-of-range symbol skips from ST_RD_LEN to ST_DONE. The rank scan runs through the
// single read port of the length memory. After reset the block sweeps the length
// memory before accepting. A pending result waits in the output register; new items
// are taken meanwhile, and a read that finishes first waits until that register frees.
module canonical_huffman_code_builder_top import chcb_pkg::*; #(
	parameter int SYMBOLS = SYMBOLS_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // symbol[8:0], code_length[12:9], zero pad
	input  logic [OP_W-1:0]      s_axis_tuser,  // operation[1:0]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // code[14:0], length_out[18:15], zero pad
	output logic                 m_axis_tuser   // over_full
);

	cmd_t                  cmd;
	sts_t                  sts;
	logic [CODE_OUT_W-1:0] code;
	logic [LEN_W-1:0]      length_out;

	chcb_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.operation     (op_t'(s_axis_tuser)),
		.sts           (sts),
		.cmd           (cmd)
	);

	chcb_dp #(
		.SYMBOLS (SYMBOLS),
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.symbol        (s_axis_tdata[SYM_W-1:0]),
		.code_length   (s_axis_tdata[SYM_W+LEN_W-1:SYM_W]),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.out_valid     (m_axis_tvalid),
		.code          (code),
		.length_out    (length_out),
		.over_full     (m_axis_tuser)
	);

	assign s_axis_tready = cmd.accept;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, length_out, code};

endmodule

// ===== hw/rtl/chcb_ctrl.sv =====
// Controller FSM for the canonical Huffman code builder.
// Sequences clear sweep, load, and read (rank scan, first-code steps, code sum, output hand-off).
// Depends on chcb_pkg.
module chcb_ctrl import chcb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  op_t  operation,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (operation)
						OP_CLEAR: state_nxt = ST_CLEAR;
						OP_LOAD:  state_nxt = sts.sym_ok ? ST_LOAD : ST_IDLE;
						OP_READ:  state_nxt = ST_RD_LEN;
						default:  state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_LOAD:   state_nxt = ST_IDLE;
			ST_RD_LEN: state_nxt = sts.rd_skip ? ST_DONE : ST_RANK;
			ST_RANK: begin
				if (sts.scan_done) state_nxt = ST_FIRST;
			end
			ST_FIRST: begin
				if (sts.first_done) state_nxt = ST_SUM;
			end
			ST_SUM: state_nxt = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				cmd.accept = 1'b1;
				if (s_axis_tvalid) begin
					unique case (operation)
						OP_CLEAR: cmd.clr_start = 1'b1;
						OP_LOAD:  cmd.ld_issue  = sts.sym_ok;
						OP_READ:  cmd.rd_issue  = 1'b1;
						default:  cmd.accept    = 1'b1;
					endcase
				end
			end
			ST_LOAD:   cmd.ld_commit = 1'b1;
			ST_RD_LEN: cmd.rd_latch  = 1'b1;
			ST_RANK:   cmd.rank_step = 1'b1;
			ST_FIRST:  cmd.first_step = !sts.first_done;
			ST_SUM:    cmd.sum = 1'b1;
			ST_DONE:   cmd.out_load = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/chcb_dp.sv =====
// Datapath for the canonical Huffman code builder.
// Holds the length memory, per-length counts, scan counters and output register.
// Depends on chcb_pkg; driven by chcb_ctrl commands.
module chcb_dp import chcb_pkg::*; #(
	parameter int SYMBOLS = SYMBOLS_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [SYM_W-1:0]      symbol,
	input  logic [LEN_W-1:0]      code_length,
	input  logic                  m_axis_tready,
	output sts_t                  sts,
	output logic                  out_valid,
	output logic [CODE_OUT_W-1:0] code,
	output logic [LEN_W-1:0]      length_out,
	output logic                  over_full
);

	localparam int ADDR_W = $clog2(SYMBOLS);
	localparam int CNT_W  = $clog2(SYMBOLS + 1);
	localparam int CODE_W = CNT_W + MAX_LEN + 2;
	localparam int B_W    = $clog2(MAX_LEN + 2);

	logic [LEN_W-1:0]  mem_q [SYMBOLS];
	logic [LEN_W-1:0]  rdata_q;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [LEN_W-1:0]  wdata;
	logic              we;

	logic [ADDR_W-1:0] addr_q, idx_q;
	logic [LEN_W-1:0]  len_q, stored_q;
	logic              range_q, pend_s1;
	logic [CNT_W-1:0]  rank_q;
	logic [CNT_W-1:0]  counts_q [CNT_DEPTH];
	logic [B_W-1:0]    b_q;
	logic [CODE_W-1:0] next_q, code_q;
	logic [LEN_W-1:0]  len_sat, cnt_idx;
	logic              sym_ok, idx_lt;

	logic              out_valid_q, out_flag_q;
	logic [CODE_OUT_W-1:0] out_code_q;
	logic [LEN_W-1:0]  out_len_q;

	assign sym_ok  = int'(symbol) < SYMBOLS;
	assign len_sat = (int'(code_length) > MAX_LEN) ? LEN_W'(MAX_LEN) : code_length;
	assign idx_lt  = idx_q < addr_q;
	assign cnt_idx = LEN_W'(b_q - B_W'(1));

	// single port pair: one write, one registered read
	assign raddr = cmd.rank_step ? idx_q : ADDR_W'(symbol);
	assign we    = cmd.ld_commit | cmd.clr_step;
	assign waddr = cmd.ld_commit ? addr_q : idx_q;
	assign wdata = cmd.ld_commit ? len_q : '0;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_issue || cmd.rd_issue) begin
			addr_q  <= ADDR_W'(symbol);
			len_q   <= len_sat;
			range_q <= sym_ok;
		end
		if (cmd.rd_latch) begin
			stored_q <= sts.rd_skip ? '0 : rdata_q;
			code_q   <= '0;
			rank_q   <= '0;
			next_q   <= '0;
			b_q      <= B_W'(1);
		end
		if (cmd.rank_step && pend_s1 && rdata_q == stored_q) begin
			rank_q <= rank_q + CNT_W'(1);
		end
		if (cmd.first_step) begin
			next_q <= (next_q + CODE_W'(counts_q[cnt_idx])) << 1;
			b_q    <= b_q + B_W'(1);
		end
		if (cmd.sum) begin
			code_q <= next_q + CODE_W'(rank_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.clr_start || cmd.rd_latch) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.clr_step) begin
				idx_q <= idx_q + ADDR_W'(1);
			end else if (cmd.rank_step) begin
				pend_s1 <= idx_lt;
				if (idx_lt) idx_q <= idx_q + ADDR_W'(1);
			end
		end
	end

	// length 0 entry stays zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CNT_DEPTH; i++) counts_q[i] <= '0;
		end else if (cmd.clr_start) begin
			for (int i = 0; i < CNT_DEPTH; i++) counts_q[i] <= '0;
		end else if (cmd.ld_commit) begin
			for (int i = 1; i < CNT_DEPTH; i++) begin
				counts_q[i] <= counts_q[i]
					- CNT_W'(rdata_q == LEN_W'(i) && counts_q[i] != '0)
					+ CNT_W'(len_q == LEN_W'(i));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_code_q <= CODE_OUT_W'(code_q);
			out_len_q  <= stored_q;
			out_flag_q <= (code_q >> stored_q) != '0;
		end
	end

	always_comb begin
		sts.sym_ok     = sym_ok;
		sts.clr_done   = idx_q == ADDR_W'(SYMBOLS - 1);
		sts.rd_skip    = !range_q || rdata_q == '0;
		sts.scan_done  = !idx_lt && !pend_s1;
		sts.first_done = b_q > B_W'(stored_q);
		sts.out_free   = !out_valid_q || m_axis_tready;
	end

	assign out_valid  = out_valid_q;
	assign code       = out_code_q;
	assign length_out = out_len_q;
	assign over_full  = out_flag_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten while pending");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rank_step |-> idx_q <= addr_q)
		else $error("rank scan ran past the symbol");

	a_stored_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_latch && !sts.rd_skip) |=> (stored_q != '0 && int'(stored_q) <= MAX_LEN))
		else $error("stored length out of range");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ld_commit && cmd.clr_step))
		else $error("load and clear sweep both write memory");

endmodule
